// ----- rtl/oriented_quad_bounding_box_unit_defines.svh -----
// Assertion macros used by the checker file.
`ifndef ORIENTED_QUAD_BOUNDING_BOX_UNIT_DEFINES_SVH
`define ORIENTED_QUAD_BOUNDING_BOX_UNIT_DEFINES_SVH

// Same-cycle implication.
`define OQBB_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define OQBB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/oqbb_pkg.sv -----
`default_nettype none
package oqbb_pkg;

    localparam int NUM_CORNERS = 4;
    localparam int NUM_STAGES  = 13;
    localparam int TRIG_DELAY  = 4;
    localparam int BODY_DELAY  = 8;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam int ROT_W  = 27;
    localparam int SCL_W  = 44;
    localparam int X_W    = 37;
    localparam int HI_W   = 49;
    localparam int LO_W   = 53;
    localparam int TERM_W = 40;
    localparam int P_W    = 41;

    localparam logic [30:0] SIN_A   = 31'd1686629713;
    localparam logic [29:0] SIN_B   = 30'd688904866;
    localparam logic [26:0] SIN_C   = 27'd76016977;
    localparam logic [14:0] QUARTER = 15'd16384;

    localparam logic [15:0] ASPECT_RESET = 16'd256;
    localparam logic [15:0] SCALE_RESET  = 16'd256;

    // bit k set: corner k lies on the positive side
    localparam logic [NUM_CORNERS-1:0] CORNER_POS_X = 4'b0110;
    localparam logic [NUM_CORNERS-1:0] CORNER_POS_Y = 4'b1100;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ASPECT_RATIO = 3'd0,
        CFG_IMAGE_ANGLE  = 3'd1,
        CFG_IMAGE_SCALE  = 3'd2,
        CFG_CENTER_X     = 3'd3,
        CFG_CENTER_Y     = 3'd4,
        CFG_ATTACHED     = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic        [15:0] body_angle;
        logic signed [31:0] body_x;
        logic signed [31:0] body_y;
    } in_t;

    typedef struct packed {
        logic signed [31:0] min_x;
        logic signed [31:0] min_y;
        logic signed [31:0] max_x;
        logic signed [31:0] max_y;
    } out_t;

    typedef logic signed [X_W-1:0] coord_t;
    typedef coord_t [NUM_CORNERS-1:0] coord_vec_t;
    typedef logic signed [P_W-1:0] pos_t;
    typedef pos_t [NUM_CORNERS-1:0] pos_vec_t;

    function automatic logic signed [31:0] sat32(input logic signed [P_W-1:0] v);
        logic [P_W-32:0] top;
        top = v[P_W-1:31];
        if (top == '0 || top == '1) begin
            return v[31:0];
        end else if (v[P_W-1]) begin
            return 32'sh80000000;
        end else begin
            return 32'sh7FFFFFFF;
        end
    endfunction

endpackage
`default_nettype wire

// ----- rtl/oqbb_sin.sv -----
`default_nettype none
module oqbb_sin (
    input  wire logic               aclk,
    input  wire logic               en,
    input  wire logic        [15:0] angle,
    output logic signed      [31:0] sin_q30
);

    logic [14:0] r0;
    logic [14:0] z_next;
    logic [29:0] z2_prod;

    logic [14:0] z_reg [3];
    logic [28:0] z2_reg [2];
    logic [2:0]  neg_reg;
    logic [26:0] t_reg;
    logic [29:0] v_reg;
    logic signed [31:0] sin_reg;

    logic [55:0] t_prod;
    logic [26:0] t_next;
    logic [29:0] u;
    logic [58:0] v_prod;
    logic [29:0] v_next;
    logic [30:0] w;
    logic [45:0] s_prod;
    logic [30:0] s;
    logic signed [31:0] sin_next;

    always_comb begin
        r0      = {1'b0, angle[13:0]};
        z_next  = angle[14] ? (oqbb_pkg::QUARTER - r0) : r0;
        z2_prod = z_next * z_next;
        t_prod  = oqbb_pkg::SIN_C * z2_reg[0];
        t_next  = t_prod[54:28];
        u       = oqbb_pkg::SIN_B - 30'(t_reg);
        v_prod  = u * z2_reg[1];
        v_next  = v_prod[57:28];
        w       = oqbb_pkg::SIN_A - 31'(v_reg);
        s_prod  = w * z_reg[2];
        s       = s_prod[44:14];
        sin_next = neg_reg[2] ? -$signed({1'b0, s}) : $signed({1'b0, s});
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            z_reg[0]  <= z_next;
            z_reg[1]  <= z_reg[0];
            z_reg[2]  <= z_reg[1];
            z2_reg[0] <= z2_prod[28:0];
            z2_reg[1] <= z2_reg[0];
            neg_reg   <= {neg_reg[1:0], angle[15]};
            t_reg     <= t_next;
            v_reg     <= v_next;
            sin_reg   <= sin_next;
        end
    end

    assign sin_q30 = sin_reg;

endmodule
`default_nettype wire

// ----- rtl/oqbb_img.sv -----
`default_nettype none
module oqbb_img (
    input  wire logic                      aclk,
    input  wire logic                      en,
    input  wire logic signed        [31:0] cos_img,
    input  wire logic signed        [31:0] sin_img,
    input  wire logic               [15:0] aspect_ratio,
    input  wire logic               [15:0] image_scale,
    input  wire logic signed        [31:0] center_x,
    input  wire logic signed        [31:0] center_y,
    output oqbb_pkg::coord_vec_t           x_corner,
    output oqbb_pkg::coord_vec_t           y_corner
);

    logic signed [16:0] a_s;
    logic signed [16:0] sc_s;
    logic signed [48:0] p_next, r_next;
    logic signed [48:0] p_reg, r_reg;
    logic signed [31:0] c_reg, s_reg;

    logic signed [49:0] pw, rw, qw, sw;
    logic signed [49:0] sum_x [oqbb_pkg::NUM_CORNERS];
    logic signed [49:0] sum_y [oqbb_pkg::NUM_CORNERS];
    logic signed [oqbb_pkg::ROT_W-1:0] rx_reg [oqbb_pkg::NUM_CORNERS];
    logic signed [oqbb_pkg::ROT_W-1:0] ry_reg [oqbb_pkg::NUM_CORNERS];

    logic signed [oqbb_pkg::SCL_W-1:0] mx_reg [oqbb_pkg::NUM_CORNERS];
    logic signed [oqbb_pkg::SCL_W-1:0] my_reg [oqbb_pkg::NUM_CORNERS];
    logic signed [oqbb_pkg::SCL_W-1:0] mx_rnd [oqbb_pkg::NUM_CORNERS];
    logic signed [oqbb_pkg::SCL_W-1:0] my_rnd [oqbb_pkg::NUM_CORNERS];

    oqbb_pkg::coord_vec_t x_next, y_next, x_reg, y_reg;

    always_comb begin
        a_s    = $signed({1'b0, aspect_ratio});
        sc_s   = $signed({1'b0, image_scale});
        p_next = cos_img * a_s;
        r_next = sin_img * a_s;
        pw     = 50'(p_reg);
        rw     = 50'(r_reg);
        qw     = 50'(s_reg) <<< 8;
        sw     = 50'(c_reg) <<< 8;
        for (int k = 0; k < oqbb_pkg::NUM_CORNERS; k++) begin
            sum_x[k] = (oqbb_pkg::CORNER_POS_X[k] ? pw : -pw)
                     - (oqbb_pkg::CORNER_POS_Y[k] ? qw : -qw) + 50'sd4194304;
            sum_y[k] = (oqbb_pkg::CORNER_POS_X[k] ? rw : -rw)
                     + (oqbb_pkg::CORNER_POS_Y[k] ? sw : -sw) + 50'sd4194304;
            mx_rnd[k] = (mx_reg[k] + 44'sd128) >>> 8;
            my_rnd[k] = (my_reg[k] + 44'sd128) >>> 8;
            x_next[k] = oqbb_pkg::X_W'(mx_rnd[k]) + oqbb_pkg::X_W'(center_x);
            y_next[k] = oqbb_pkg::X_W'(my_rnd[k]) + oqbb_pkg::X_W'(center_y);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg <= p_next;
            r_reg <= r_next;
            c_reg <= cos_img;
            s_reg <= sin_img;
            for (int k = 0; k < oqbb_pkg::NUM_CORNERS; k++) begin
                rx_reg[k] <= sum_x[k][49:23];
                ry_reg[k] <= sum_y[k][49:23];
                mx_reg[k] <= rx_reg[k] * sc_s;
                my_reg[k] <= ry_reg[k] * sc_s;
            end
            x_reg <= x_next;
            y_reg <= y_next;
        end
    end

    assign x_corner = x_reg;
    assign y_corner = y_reg;

endmodule
`default_nettype wire

// ----- rtl/oqbb_body.sv -----
`default_nettype none
module oqbb_body (
    input  wire logic                      aclk,
    input  wire logic                      en,
    input  wire logic                      attached,
    input  wire oqbb_pkg::coord_vec_t      x_corner,
    input  wire oqbb_pkg::coord_vec_t      y_corner,
    input  wire logic signed        [31:0] cos_body,
    input  wire logic signed        [31:0] sin_body,
    input  wire logic signed        [31:0] body_x,
    input  wire logic signed        [31:0] body_y,
    output oqbb_pkg::pos_vec_t             px,
    output oqbb_pkg::pos_vec_t             py
);

    // product order per corner: x*cos, y*sin, x*sin, y*cos
    logic signed [oqbb_pkg::HI_W-1:0]   hi_next   [oqbb_pkg::NUM_CORNERS][4];
    logic signed [oqbb_pkg::LO_W-1:0]   lo_next   [oqbb_pkg::NUM_CORNERS][4];
    logic signed [oqbb_pkg::HI_W-1:0]   hi_reg    [oqbb_pkg::NUM_CORNERS][4];
    logic signed [oqbb_pkg::LO_W-1:0]   lo_reg    [oqbb_pkg::NUM_CORNERS][4];
    logic signed [oqbb_pkg::LO_W:0]     lo_rnd    [oqbb_pkg::NUM_CORNERS][4];
    logic signed [oqbb_pkg::HI_W:0]     hi_sum    [oqbb_pkg::NUM_CORNERS][4];
    logic signed [oqbb_pkg::TERM_W-1:0] term_next [oqbb_pkg::NUM_CORNERS][4];
    logic signed [oqbb_pkg::TERM_W-1:0] term_reg  [oqbb_pkg::NUM_CORNERS][4];

    oqbb_pkg::coord_vec_t x_reg [2];
    oqbb_pkg::coord_vec_t y_reg [2];
    logic signed [31:0] bx_reg [2];
    logic signed [31:0] by_reg [2];

    oqbb_pkg::coord_t   opnd [4];
    logic signed [31:0] coef [4];
    oqbb_pkg::pos_vec_t px_next, py_next, px_reg, py_reg;

    always_comb begin
        for (int k = 0; k < oqbb_pkg::NUM_CORNERS; k++) begin
            opnd[0] = x_corner[k];
            opnd[1] = y_corner[k];
            opnd[2] = x_corner[k];
            opnd[3] = y_corner[k];
            coef[0] = cos_body;
            coef[1] = sin_body;
            coef[2] = sin_body;
            coef[3] = cos_body;
            for (int j = 0; j < 4; j++) begin
                hi_next[k][j] = $signed(opnd[j][oqbb_pkg::X_W-1:20]) * coef[j];
                lo_next[k][j] = $signed({1'b0, opnd[j][19:0]}) * coef[j];
                lo_rnd[k][j]  = (54'(lo_reg[k][j]) + 54'sd536870912) >>> 20;
                hi_sum[k][j]  = 50'(hi_reg[k][j]) + 50'(lo_rnd[k][j]);
                term_next[k][j] = oqbb_pkg::TERM_W'(hi_sum[k][j] >>> 10);
            end
            if (attached) begin
                px_next[k] = oqbb_pkg::P_W'(term_reg[k][0]) - oqbb_pkg::P_W'(term_reg[k][1])
                           + oqbb_pkg::P_W'(bx_reg[1]);
                py_next[k] = oqbb_pkg::P_W'(term_reg[k][2]) + oqbb_pkg::P_W'(term_reg[k][3])
                           + oqbb_pkg::P_W'(by_reg[1]);
            end else begin
                px_next[k] = oqbb_pkg::P_W'(x_reg[1][k]);
                py_next[k] = oqbb_pkg::P_W'(y_reg[1][k]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            hi_reg   <= hi_next;
            lo_reg   <= lo_next;
            term_reg <= term_next;
            x_reg[0] <= x_corner;
            x_reg[1] <= x_reg[0];
            y_reg[0] <= y_corner;
            y_reg[1] <= y_reg[0];
            bx_reg[0] <= body_x;
            bx_reg[1] <= bx_reg[0];
            by_reg[0] <= body_y;
            by_reg[1] <= by_reg[0];
            px_reg   <= px_next;
            py_reg   <= py_next;
        end
    end

    assign px = px_reg;
    assign py = py_reg;

endmodule
`default_nettype wire

// ----- rtl/oqbb_minmax.sv -----
`default_nettype none
module oqbb_minmax (
    input  wire logic               aclk,
    input  wire logic               en,
    input  wire oqbb_pkg::pos_vec_t px,
    input  wire oqbb_pkg::pos_vec_t py,
    output oqbb_pkg::out_t          result
);

    oqbb_pkg::pos_t lo_x_next [2], lo_y_next [2], hi_x_next [2], hi_y_next [2];
    oqbb_pkg::pos_t lo_x_reg  [2], lo_y_reg  [2], hi_x_reg  [2], hi_y_reg  [2];
    oqbb_pkg::pos_t lo_x, lo_y, hi_x, hi_y;
    oqbb_pkg::out_t result_next, result_reg;

    always_comb begin
        for (int h = 0; h < 2; h++) begin
            lo_x_next[h] = ($signed(px[2*h+1]) < $signed(px[2*h])) ? px[2*h+1] : px[2*h];
            hi_x_next[h] = ($signed(px[2*h+1]) > $signed(px[2*h])) ? px[2*h+1] : px[2*h];
            lo_y_next[h] = ($signed(py[2*h+1]) < $signed(py[2*h])) ? py[2*h+1] : py[2*h];
            hi_y_next[h] = ($signed(py[2*h+1]) > $signed(py[2*h])) ? py[2*h+1] : py[2*h];
        end
        lo_x = ($signed(lo_x_reg[1]) < $signed(lo_x_reg[0])) ? lo_x_reg[1] : lo_x_reg[0];
        hi_x = ($signed(hi_x_reg[1]) > $signed(hi_x_reg[0])) ? hi_x_reg[1] : hi_x_reg[0];
        lo_y = ($signed(lo_y_reg[1]) < $signed(lo_y_reg[0])) ? lo_y_reg[1] : lo_y_reg[0];
        hi_y = ($signed(hi_y_reg[1]) > $signed(hi_y_reg[0])) ? hi_y_reg[1] : hi_y_reg[0];
        result_next.min_x = oqbb_pkg::sat32(lo_x);
        result_next.min_y = oqbb_pkg::sat32(lo_y);
        result_next.max_x = oqbb_pkg::sat32(hi_x);
        result_next.max_y = oqbb_pkg::sat32(hi_y);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lo_x_reg   <= lo_x_next;
            hi_x_reg   <= hi_x_next;
            lo_y_reg   <= lo_y_next;
            hi_y_reg   <= hi_y_next;
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule
`default_nettype wire

// ----- rtl/oriented_quad_bounding_box_unit.sv -----
// Axis-aligned bounding box of a rotated, scaled image rectangle, optionally carried by a
// body pose. One pose request is taken per clock unless the pipeline stalls; each result
// passes through a pipeline of four sine stages, four image-corner stages, three
// body-transform stages and two min/max stages. The whole pipeline stalls together while the
// output register holds an untaken result, so s_ready follows m_ready then.
// Configuration registers (index: aspect_ratio 0, image_angle 1, image_scale 2, center_x 3,
// center_y 4, attached_to_body 5) are written through cfg_valid/cfg_index/cfg_data,
// cfg_ready is always high, indexes 6 and 7 are ignored, and writes belong only to times when
// no request is in flight.
`default_nettype none
module oriented_quad_bounding_box_unit (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire oqbb_pkg::in_t                       s_data,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output oqbb_pkg::out_t                           m_data,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [oqbb_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [oqbb_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic               en;
    logic [oqbb_pkg::NUM_STAGES-1:0] valid_reg;

    logic        [15:0] aspect_reg;
    logic        [15:0] img_angle_reg;
    logic        [15:0] scale_reg;
    logic signed [31:0] center_x_reg;
    logic signed [31:0] center_y_reg;
    logic               attached_reg;

    logic signed [31:0] sin_body, cos_body, sin_img, cos_img;
    logic signed [31:0] sin_b_reg [oqbb_pkg::TRIG_DELAY];
    logic signed [31:0] cos_b_reg [oqbb_pkg::TRIG_DELAY];
    logic signed [31:0] bx_reg [oqbb_pkg::BODY_DELAY];
    logic signed [31:0] by_reg [oqbb_pkg::BODY_DELAY];

    oqbb_pkg::coord_vec_t x_corner, y_corner;
    oqbb_pkg::pos_vec_t   px, py;

    assign en        = !m_valid || m_ready;
    assign s_ready   = en;
    assign cfg_ready = 1'b1;
    assign m_valid   = valid_reg[oqbb_pkg::NUM_STAGES-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[oqbb_pkg::NUM_STAGES-2:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            aspect_reg    <= oqbb_pkg::ASPECT_RESET;
            img_angle_reg <= '0;
            scale_reg     <= oqbb_pkg::SCALE_RESET;
            center_x_reg  <= '0;
            center_y_reg  <= '0;
            attached_reg  <= 1'b0;
        end else if (cfg_valid) begin
            case (oqbb_pkg::cfg_index_t'(cfg_index))
                oqbb_pkg::CFG_ASPECT_RATIO: aspect_reg    <= cfg_data[15:0];
                oqbb_pkg::CFG_IMAGE_ANGLE:  img_angle_reg <= cfg_data[15:0];
                oqbb_pkg::CFG_IMAGE_SCALE:  scale_reg     <= cfg_data[15:0];
                oqbb_pkg::CFG_CENTER_X:     center_x_reg  <= $signed(cfg_data);
                oqbb_pkg::CFG_CENTER_Y:     center_y_reg  <= $signed(cfg_data);
                oqbb_pkg::CFG_ATTACHED:     attached_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    oqbb_sin u_sin_body (
        .aclk    (aclk),
        .en      (en),
        .angle   (s_data.body_angle),
        .sin_q30 (sin_body)
    );

    oqbb_sin u_cos_body (
        .aclk    (aclk),
        .en      (en),
        .angle   (s_data.body_angle + {oqbb_pkg::QUARTER[14], 14'd0}),
        .sin_q30 (cos_body)
    );

    oqbb_sin u_sin_img (
        .aclk    (aclk),
        .en      (en),
        .angle   (img_angle_reg),
        .sin_q30 (sin_img)
    );

    oqbb_sin u_cos_img (
        .aclk    (aclk),
        .en      (en),
        .angle   (img_angle_reg + {oqbb_pkg::QUARTER[14], 14'd0}),
        .sin_q30 (cos_img)
    );

    // align body pose with the image corners
    always_ff @(posedge aclk) begin
        if (en) begin
            sin_b_reg[0] <= sin_body;
            cos_b_reg[0] <= cos_body;
            for (int i = 1; i < oqbb_pkg::TRIG_DELAY; i++) begin
                sin_b_reg[i] <= sin_b_reg[i-1];
                cos_b_reg[i] <= cos_b_reg[i-1];
            end
            bx_reg[0] <= s_data.body_x;
            by_reg[0] <= s_data.body_y;
            for (int i = 1; i < oqbb_pkg::BODY_DELAY; i++) begin
                bx_reg[i] <= bx_reg[i-1];
                by_reg[i] <= by_reg[i-1];
            end
        end
    end

    oqbb_img u_img (
        .aclk         (aclk),
        .en           (en),
        .cos_img      (cos_img),
        .sin_img      (sin_img),
        .aspect_ratio (aspect_reg),
        .image_scale  (scale_reg),
        .center_x     (center_x_reg),
        .center_y     (center_y_reg),
        .x_corner     (x_corner),
        .y_corner     (y_corner)
    );

    oqbb_body u_body (
        .aclk     (aclk),
        .en       (en),
        .attached (attached_reg),
        .x_corner (x_corner),
        .y_corner (y_corner),
        .cos_body (cos_b_reg[oqbb_pkg::TRIG_DELAY-1]),
        .sin_body (sin_b_reg[oqbb_pkg::TRIG_DELAY-1]),
        .body_x   (bx_reg[oqbb_pkg::BODY_DELAY-1]),
        .body_y   (by_reg[oqbb_pkg::BODY_DELAY-1]),
        .px       (px),
        .py       (py)
    );

    oqbb_minmax u_minmax (
        .aclk   (aclk),
        .en     (en),
        .px     (px),
        .py     (py),
        .result (m_data)
    );

endmodule
`default_nettype wire

// ----- rtl/oqbb_checker.sv -----
`default_nettype none
`include "oriented_quad_bounding_box_unit_defines.svh"
module oqbb_checker (
    input wire logic           aclk,
    input wire logic           aresetn,
    input wire logic           s_ready,
    input wire logic           m_valid,
    input wire logic           m_ready,
    input wire oqbb_pkg::out_t m_data
);

    `OQBB_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "result dropped or changed while stalled")
    `OQBB_ASSERT_IMPLY(a_x_order, aclk, aresetn, m_valid, $signed(m_data.min_x) <= $signed(m_data.max_x), "min_x above max_x")
    `OQBB_ASSERT_IMPLY(a_y_order, aclk, aresetn, m_valid, $signed(m_data.min_y) <= $signed(m_data.max_y), "min_y above max_y")
    `OQBB_ASSERT_IMPLY(a_ready_free, aclk, aresetn, !m_valid || m_ready, s_ready, "request refused with free output")

endmodule

bind oriented_quad_bounding_box_unit oqbb_checker u_oqbb_checker (.*);
`default_nettype wire
